// ----- rtl/ksel_pkg.sv -----
// ksel_pkg: sizes and shared types for the k-th smallest selector
// used by the interfaces, the sorting cell and the top level
package ksel_pkg;

    localparam int MAX_RANK = 64;
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = $clog2(MAX_RANK + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [RANK_W-1:0]         t_rank;

    // what one cell hands to its right-hand neighbour
    typedef struct packed {
        logic   valid;
        logic   le;
        t_value value;
    } t_link;

endpackage

// ----- rtl/ksel_if.sv -----
// ksel_if: valid/ready channels of the k-th smallest selector
// depends on ksel_pkg for the value type
interface ksel_in_if;
    logic             valid;
    logic             ready;
    ksel_pkg::t_value sample_value;
    logic             last_of_set;

    modport source (output valid, output sample_value, output last_of_set, input ready);
    modport sink   (input valid, input sample_value, input last_of_set, output ready);
endinterface

interface ksel_out_if;
    logic             valid;
    logic             ready;
    ksel_pkg::t_value kth_value;
    logic             found;

    modport source (output valid, output kth_value, output found, input ready);
    modport sink   (input valid, input kth_value, input found, output ready);
endinterface

// ----- rtl/ksel_cell.sv -----
// ksel_cell: one compare-and-shift cell of the sorted chain
// depends on ksel_pkg for t_link and t_value
module ksel_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_ins,
    input  logic             i_clr,
    input  ksel_pkg::t_value i_sample,
    input  ksel_pkg::t_link  i_left,
    output ksel_pkg::t_link  o_link
);

    logic             r_valid;
    ksel_pkg::t_value r_value;
    logic             n_valid;
    ksel_pkg::t_value n_value;
    logic             le;

    // entry beyond the rank is treated as gone
    assign le = r_valid && i_en && (r_value <= i_sample);

    always_comb begin
        n_valid = r_valid && i_en;
        n_value = r_value;
        priority if (i_clr) begin
            n_valid = 1'b0;
        end else if (i_ins) begin
            priority if (le) begin
                n_valid = 1'b1;
            end else if (i_left.le) begin
                n_valid = i_en;
                n_value = i_sample;
            end else begin
                n_valid = i_left.valid && i_en;
                n_value = i_left.value;
            end
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid && i_en;
    assign o_link.le    = le;
    assign o_link.value = r_value;

endmodule

// ----- rtl/kth_smallest_select_top.sv -----
// kth_smallest_select_top: streaming k-th smallest selector
// depends on ksel_pkg, ksel_if (ksel_in_if, ksel_out_if) and ksel_cell
//
// Words of a set arrive on i_in, one signed value each, last_of_set on
// the final one. A chain of MAX_RANK compare-and-shift cells keeps the
// k smallest values in ascending order; each accepted word is inserted
// with every cell comparing it against its own entry and taking the
// word, its left neighbour's entry or keeping its own.
// A word without last_of_set gives no result and keeps i_in ready, so the
// next word can follow in the next cycle. The word with last_of_set is
// inserted and i_in drops ready; once the output register is free, the
// cell at rank k is read into it and the chain is cleared, and the result
// then shows on o_out from the output register.
// found is 0 (with kth_value 0) when the set held fewer than k values.
// i_cfg_we/i_cfg_data write rank k (0 reads as 1, above MAX_RANK as
// MAX_RANK); write it only while no set result is outstanding.
// While o_out stalls, words of the next set are still taken; the readout of
// a second completed set waits for the output register, with i_in not ready.
// Reset empties the chain, drops any pending result and sets k to 1.
module kth_smallest_select_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  ksel_pkg::t_rank        i_cfg_data,
    ksel_in_if.sink                i_in,
    ksel_out_if.source             o_out
);

    localparam int N = ksel_pkg::MAX_RANK;

    ksel_pkg::t_rank  r_rank;
    ksel_pkg::t_rank  k_eff;
    logic             r_busy;
    logic             n_busy;
    logic             r_out_valid;
    logic             n_out_valid;
    ksel_pkg::t_value r_out_value;
    logic             r_out_found;

    ksel_pkg::t_link  link [N+1];
    logic [N-1:0]     en;
    logic [N-1:0]     sel;
    logic [N-1:0]     cell_valid;
    logic             ins;
    logic             readout;
    ksel_pkg::t_value rd_value;
    logic             rd_found;

    always_comb begin
        priority if (r_rank == '0) begin
            k_eff = ksel_pkg::t_rank'(1);
        end else if (r_rank > ksel_pkg::t_rank'(N)) begin
            k_eff = ksel_pkg::t_rank'(N);
        end else begin
            k_eff = r_rank;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            en[i]  = ksel_pkg::t_rank'(i) < k_eff;
            sel[i] = ksel_pkg::t_rank'(i + 1) == k_eff;
        end
    end

    assign i_in.ready = !r_busy;
    assign ins        = i_in.valid && i_in.ready;
    assign readout    = r_busy && (!r_out_valid || o_out.ready);

    // head of the chain: the word always goes in at or after cell 0
    assign link[0].valid = 1'b1;
    assign link[0].le    = 1'b1;
    assign link[0].value = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        ksel_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en[g]),
            .i_ins    (ins),
            .i_clr    (readout),
            .i_sample (i_in.sample_value),
            .i_left   (link[g]),
            .o_link   (link[g+1])
        );
        assign cell_valid[g] = link[g+1].valid;
    end

    // one-hot pick of the cell at rank k
    always_comb begin
        rd_value = '0;
        rd_found = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (sel[i] && cell_valid[i]) begin
                rd_value = rd_value | link[i+1].value;
                rd_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        priority if (readout) begin
            n_busy = 1'b0;
        end else if (ins && i_in.last_of_set) begin
            n_busy = 1'b1;
        end else begin
            n_busy = r_busy;
        end
        n_out_valid = r_out_valid;
        priority if (readout) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= ksel_pkg::t_rank'(1);
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rank <= i_cfg_data;
            end
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (readout) begin
            r_out_value <= rd_value;
            r_out_found <= rd_found;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kth_value = r_out_value;
    assign o_out.found     = r_out_found;

    // kept entries always form an unbroken run from cell 0
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("kept entries not contiguous");

    // readout empties the whole chain
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        readout |=> cell_valid == '0)
        else $error("chain not cleared after readout");

    // no word enters while a completed set awaits readout
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !readout |=> r_busy && $stable(cell_valid))
        else $error("chain changed while readout pending");

endmodule

// ----- tb/kth_smallest_select_top_tb.sv -----
// kth_smallest_select_top_tb: self-checking bench for the k-th smallest selector
// drives sets through ksel_in_if, predicts each set's answer and checks ksel_out_if
// depends on ksel_pkg, ksel_if and kth_smallest_select_top
module kth_smallest_select_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam ksel_pkg::t_value VAL_MIN     = 32'sh8000_0000;
    localparam ksel_pkg::t_value VAL_MAX     = 32'sh7fff_ffff;
    localparam ksel_pkg::t_rank  RANK_ZERO   = 7'd0;
    localparam ksel_pkg::t_rank  RANK_ONE    = 7'd1;
    localparam ksel_pkg::t_rank  RANK_TOP    = ksel_pkg::t_rank'(ksel_pkg::MAX_RANK);
    localparam ksel_pkg::t_rank  RANK_ABOVE  = ksel_pkg::t_rank'(ksel_pkg::MAX_RANK + 1);
    localparam ksel_pkg::t_rank  RANK_ALL1   = 7'd127;
    localparam int               SETTLE      = 8;
    localparam int               LONG_STALL  = 300;
    localparam int               IDLE_PCT    = 22;
    localparam int               PHASE_WORDS = 45;

    typedef struct {
        ksel_pkg::t_value value;
        logic             last;
    } t_word;

    typedef struct {
        ksel_pkg::t_value kth;
        logic             found;
    } t_answer;

    logic clk;
    logic rst_n;
    logic cfg_we;
    ksel_pkg::t_rank cfg_data;

    ksel_in_if  in_if ();
    ksel_out_if out_if ();

    kth_smallest_select_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_word   word_queue[$];
    t_answer answers[$];

    // predicted selector state
    ksel_pkg::t_value kept_vals[ksel_pkg::MAX_RANK];
    int               kept_n;
    ksel_pkg::t_rank  rank_set;

    logic idle_on;
    int   mismatches;
    int   stall_asked;
    int   stall_served;
    int   hold_left;

    function automatic int rank_in_use();
        int k;
        k = rank_set;
        if (k < 1) k = 1;
        if (k > ksel_pkg::MAX_RANK) k = ksel_pkg::MAX_RANK;
        return k;
    endfunction

    // insert one word into the sorted kept list, answer on the last word of a set
    task automatic take_word(input ksel_pkg::t_value v, input logic last);
        int k;
        int pos;
        int top;
        t_answer ans;
        k = rank_in_use();
        // a smaller rank set mid-set drops the largest kept values for good
        if (kept_n > k) kept_n = k;
        pos = 0;
        while (pos < kept_n && kept_vals[pos] <= v) pos++;
        if (pos < k) begin
            top = (kept_n < k) ? kept_n : k - 1;
            for (int i = top; i > pos; i--) kept_vals[i] = kept_vals[i-1];
            kept_vals[pos] = v;
            if (kept_n < k) kept_n++;
        end
        if (last) begin
            if (kept_n >= k) begin
                ans.kth   = kept_vals[k-1];
                ans.found = 1'b1;
            end else begin
                ans.kth   = '0;
                ans.found = 1'b0;
            end
            answers.push_back(ans);
            kept_n = 0;
        end
    endtask

    task automatic queue_word(input ksel_pkg::t_value v, input logic last);
        t_word w;
        w.value = v;
        w.last  = last;
        word_queue.push_back(w);
    endtask

    task automatic wait_idle();
        while (word_queue.size() != 0 || in_if.valid || answers.size() != 0) @(posedge clk);
    endtask

    task automatic set_rank(input ksel_pkg::t_rank r);
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= r;
        rank_set = r;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic ksel_pkg::t_value pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return ksel_pkg::t_value'($urandom_range(8)) - 4;
            default: return ksel_pkg::t_value'($urandom);
        endcase
    endfunction

    task automatic queue_random_set(input int len);
        for (int i = 0; i < len; i++) queue_word(pick_value(), i == len - 1);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // word driver
    always @(posedge clk) begin : word_driver
        t_word nxt;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                take_word(in_if.sample_value, in_if.last_of_set);
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_queue.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
                    nxt = word_queue.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.sample_value <= nxt.value;
                    in_if.last_of_set  <= nxt.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge clk) begin : answer_monitor
        t_answer exp;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected result: kth_value %0d found %0b",
                           out_if.kth_value, out_if.found);
                    mismatches++;
                end else begin
                    exp = answers.pop_front();
                    if (out_if.kth_value !== exp.kth) begin
                        $error("kth_value: expected %0d, got %0d", exp.kth, out_if.kth_value);
                        mismatches++;
                    end
                    if (out_if.found !== exp.found) begin
                        $error("found: expected %0b, got %0b", exp.found, out_if.found);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (stall_served != stall_asked) begin
                stall_served <= stall_asked;
                hold_left    <= LONG_STALL;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        ksel_pkg::t_rank phase_ranks[8];
        int              keff;
        int              len;
        int              count;
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.last_of_set  = 1'b0;
        out_if.ready       = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = RANK_ONE;
        rank_set     = RANK_ONE;
        kept_n       = 0;
        idle_on      = 1'b1;
        mismatches   = 0;
        stall_asked  = 0;
        stall_served = 0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rank 1 from reset, then the value extremes
        queue_word(5, 1'b0);
        queue_word(-3, 1'b0);
        queue_word(7, 1'b1);
        queue_word(VAL_MAX, 1'b0);
        queue_word(VAL_MIN, 1'b1);
        // rank zero reads as rank 1, single-word set
        set_rank(RANK_ZERO);
        queue_word(42, 1'b1);
        // duplicates count separately, then too few words
        set_rank(7'd3);
        queue_word(10, 1'b0);
        queue_word(10, 1'b0);
        queue_word(10, 1'b1);
        queue_word(1, 1'b0);
        queue_word(2, 1'b1);
        // rank above the maximum saturates, set too short
        set_rank(RANK_ALL1);
        queue_word(VAL_MIN, 1'b0);
        queue_word(VAL_MAX, 1'b0);
        queue_word(0, 1'b1);
        // rank lowered mid-set: largest kept values dropped
        set_rank(7'd2);
        queue_word(9, 1'b0);
        queue_word(4, 1'b0);
        queue_word(6, 1'b0);
        set_rank(RANK_ONE);
        queue_word(8, 1'b1);
        // rank raised mid-set: earlier drops stay lost
        queue_word(3, 1'b0);
        queue_word(1, 1'b0);
        set_rank(7'd3);
        queue_word(5, 1'b1);

        phase_ranks[0] = RANK_ONE;
        phase_ranks[1] = RANK_TOP;
        phase_ranks[2] = RANK_ALL1;
        phase_ranks[3] = RANK_ZERO;
        phase_ranks[4] = RANK_ABOVE;
        for (int p = 5; p < 8; p++) phase_ranks[p] = ksel_pkg::t_rank'($urandom_range(2, 12));

        foreach (phase_ranks[p]) begin
            set_rank(phase_ranks[p]);
            // one phase runs with no idling on either side
            idle_on = (p != 2);
            keff = rank_in_use();
            count = 0;
            while (count < PHASE_WORDS) begin
                if ($urandom_range(1))
                    len = $urandom_range(keff > 2 ? keff - 2 : 1, keff + 3);
                else
                    len = $urandom_range(1, keff + 3);
                queue_random_set(len);
                count += len;
            end
        end

        // receiver holds off while short sets keep coming, so the input stalls
        set_rank(7'd2);
        idle_on = 1'b0;
        stall_asked <= stall_asked + 1;
        for (int s = 0; s < 12; s++) queue_random_set(3);
        wait_idle();

        // sender paused until everything drained, then a last burst
        idle_on = 1'b1;
        for (int s = 0; s < 6; s++) queue_random_set($urandom_range(1, 5));

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ksel_pkg.sv
rtl/ksel_if.sv
rtl/ksel_cell.sv
rtl/kth_smallest_select_top.sv
tb/kth_smallest_select_top_tb.sv
